// ===== rtl/core/bbe_pkg.sv =====
// ----------------------------------------------------------------------------
// bbe_pkg
// Shared constants, types and codes for the 3x3 edge-averaging box blur.
// ----------------------------------------------------------------------------
package bbe_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int FW_W       = 11;
    localparam int FH_W       = 16;
    localparam int ROW_W      = FH_W + 1;
    localparam int PIX_W      = 24;
    localparam int CH_W       = 8;
    localparam int SUM_W      = 12;
    localparam int CNT_W      = 4;
    localparam int NUM_W      = 13;
    localparam int DEN_W      = 5;
    localparam int STEP_W     = 4;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

    localparam logic [FW_W-1:0] WIDTH_RESET  = FW_W'(MAX_WIDTH);
    localparam logic [FH_W-1:0] HEIGHT_RESET = FH_W'(1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SHIFT,
        S_SUM,
        S_DIV,
        S_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic rd;
        logic shift;
        logic sum;
        logic div_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic drop;
        logic emit;
        logic div_done;
        logic out_free;
    } t_status;

endpackage

// ===== rtl/core/bbe_ram.sv =====
// ----------------------------------------------------------------------------
// bbe_ram
// Simple dual-port RAM, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module bbe_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/bbe_ctrl.sv =====
// ----------------------------------------------------------------------------
// bbe_ctrl
// Sequencer: accept, check, line-store read, window shift, sum, divide, output.
// ----------------------------------------------------------------------------
module bbe_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  bbe_pkg::t_status i_status,
    output logic             o_ready,
    output bbe_pkg::t_cmd    o_cmd
);

    bbe_pkg::t_state r_state;
    bbe_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bbe_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            bbe_pkg::S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = bbe_pkg::S_CHECK;
                end
            end
            bbe_pkg::S_CHECK: begin
                if (i_status.drop) begin
                    n_state = bbe_pkg::S_IDLE;
                end else begin
                    o_cmd.rd = 1'b1;
                    n_state  = bbe_pkg::S_SHIFT;
                end
            end
            bbe_pkg::S_SHIFT: begin
                o_cmd.shift = 1'b1;
                n_state     = i_status.emit ? bbe_pkg::S_SUM : bbe_pkg::S_IDLE;
            end
            bbe_pkg::S_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = bbe_pkg::S_DIV;
            end
            bbe_pkg::S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_done) begin
                    n_state = bbe_pkg::S_OUT;
                end
            end
            bbe_pkg::S_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = bbe_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bbe_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/bbe_dpath.sv =====
// ----------------------------------------------------------------------------
// bbe_dpath
// Position counters, line stores, 3x3 window, masked sums, serial divider
// and the output register.
// ----------------------------------------------------------------------------
module bbe_dpath (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  bbe_pkg::t_cmd                  i_cmd,
    output bbe_pkg::t_status               o_status,
    input  logic                           i_cfg_valid,
    input  logic [bbe_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bbe_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_op,
    input  logic [bbe_pkg::CH_W-1:0]       i_in_red,
    input  logic [bbe_pkg::CH_W-1:0]       i_in_green,
    input  logic [bbe_pkg::CH_W-1:0]       i_in_blue,
    input  logic                           i_ready,
    output logic                           o_valid,
    output logic [bbe_pkg::CH_W-1:0]       o_out_red,
    output logic [bbe_pkg::CH_W-1:0]       o_out_green,
    output logic [bbe_pkg::CH_W-1:0]       o_out_blue,
    output logic                           o_frame_end
);

    localparam int PW  = bbe_pkg::PIX_W;
    localparam int CW  = bbe_pkg::CH_W;
    localparam int SW  = bbe_pkg::SUM_W;
    localparam int NW  = bbe_pkg::NUM_W;
    localparam int DW  = bbe_pkg::DEN_W;
    localparam int RW  = bbe_pkg::ROW_W;
    localparam int FWW = bbe_pkg::FW_W;
    localparam int FHW = bbe_pkg::FH_W;
    localparam int CLW = bbe_pkg::COL_W;

    // configuration and latched frame size
    logic [FWW-1:0] r_image_width;
    logic [FHW-1:0] r_image_height;
    logic [FWW-1:0] r_frame_w;
    logic [FHW-1:0] r_frame_h;

    // position and current item
    logic [RW-1:0]  r_in_row;
    logic [CLW-1:0] r_in_col;
    logic           r_op;
    logic [PW-1:0]  r_pix;

    // window, [column 0 oldest][row 0 top]
    logic [PW-1:0]  r_win [3][3];
    logic [RW-1:0]  r_orow;
    logic [CLW-1:0] r_ocol;
    logic           r_fe;

    // divider
    logic [NW-1:0]  r_num [3];
    logic [DW-1:0]  r_rem [3];
    logic [DW-1:0]  r_den;
    logic [bbe_pkg::STEP_W-1:0] r_step;

    logic [PW-1:0]  w_above;
    logic [PW-1:0]  w_two_above;
    logic           w_start;
    logic           w_in_frame;
    logic [PW-1:0]  w_pix;
    logic           w_col_wrap;
    logic           w_fe;
    logic [2:0]     w_mi;
    logic [2:0]     w_mj;
    logic [SW-1:0]  w_sum [3];
    logic [bbe_pkg::CNT_W-1:0] w_cnt;
    logic [DW:0]    w_rsh [3];
    logic [DW:0]    w_rsub [3];
    logic           w_qbit [3];

    assign w_start    = (r_in_row == '0) && (r_in_col == '0);
    assign w_in_frame = r_in_row < {1'b0, r_frame_h};
    assign w_pix      = w_in_frame ? r_pix : '0;
    assign w_col_wrap = ({1'b0, r_in_col} + FWW'(1)) >= r_frame_w;

    // output position is the frame's last pixel
    assign w_fe = ({1'b0, r_orow} + (RW + 1)'(1) == {2'b0, r_frame_h})
               && ({1'b0, r_ocol} + FWW'(1) == r_frame_w);

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= bbe_pkg::WIDTH_RESET;
            r_image_height <= bbe_pkg::HEIGHT_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == bbe_pkg::REG_IMAGE_WIDTH) begin
                r_image_width <= i_cfg_data[FWW-1:0];
            end else if (i_cfg_index == bbe_pkg::REG_IMAGE_HEIGHT) begin
                r_image_height <= i_cfg_data;
            end
        end
    end

    // position counters and frame latch
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_row  <= '0;
            r_in_col  <= '0;
            r_frame_w <= FWW'(1);
            r_frame_h <= FHW'(1);
        end else begin
            if (i_cmd.load && w_start && !i_op) begin
                if (r_image_width == '0) begin
                    r_frame_w <= FWW'(1);
                end else if (r_image_width > bbe_pkg::WIDTH_RESET) begin
                    r_frame_w <= bbe_pkg::WIDTH_RESET;
                end else begin
                    r_frame_w <= r_image_width;
                end
                r_frame_h <= (r_image_height == '0) ? FHW'(1) : r_image_height;
            end
            if (i_cmd.shift) begin
                if (w_col_wrap) begin
                    r_in_col <= '0;
                    r_in_row <= r_in_row + RW'(1);
                end else begin
                    r_in_col <= r_in_col + CLW'(1);
                end
            end
            if (i_cmd.sum && w_fe) begin
                r_in_row <= '0;
                r_in_col <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_op;
            r_pix <= {i_in_red, i_in_green, i_in_blue};
        end
    end

    bbe_ram #(.WIDTH(PW), .DEPTH(bbe_pkg::MAX_WIDTH)) u_ram_above (
        .i_clk   (i_clk),
        .i_we    (i_cmd.shift),
        .i_waddr (r_in_col),
        .i_wdata (w_pix),
        .i_re    (i_cmd.rd),
        .i_raddr (r_in_col),
        .o_rdata (w_above)
    );

    bbe_ram #(.WIDTH(PW), .DEPTH(bbe_pkg::MAX_WIDTH)) u_ram_two_above (
        .i_clk   (i_clk),
        .i_we    (i_cmd.shift),
        .i_waddr (r_in_col),
        .i_wdata (w_above),
        .i_re    (i_cmd.rd),
        .i_raddr (r_in_col),
        .o_rdata (w_two_above)
    );

    // window shift and output position
    always_ff @(posedge i_clk) begin
        if (i_cmd.shift) begin
            for (int j = 0; j < 3; j++) begin
                r_win[0][j] <= r_win[1][j];
                r_win[1][j] <= r_win[2][j];
            end
            r_win[2][0] <= w_two_above;
            r_win[2][1] <= w_above;
            r_win[2][2] <= w_pix;
            if (r_in_col != '0) begin
                r_orow <= r_in_row - RW'(1);
                r_ocol <= r_in_col - CLW'(1);
            end else begin
                r_orow <= r_in_row - RW'(2);
                r_ocol <= CLW'(r_frame_w - FWW'(1));
            end
        end
    end

    // neighborhood masks from the registered output position
    assign w_mi[0] = r_ocol != '0;
    assign w_mi[1] = 1'b1;
    assign w_mi[2] = ({1'b0, r_ocol} + FWW'(1)) < r_frame_w;
    assign w_mj[0] = r_orow != '0;
    assign w_mj[1] = 1'b1;
    assign w_mj[2] = ({1'b0, r_orow} + (RW + 1)'(1)) < {2'b0, r_frame_h};

    always_comb begin
        w_cnt = '0;
        for (int c = 0; c < 3; c++) begin
            w_sum[c] = '0;
        end
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                if (w_mi[i] && w_mj[j]) begin
                    w_cnt = w_cnt + bbe_pkg::CNT_W'(1);
                    for (int c = 0; c < 3; c++) begin
                        w_sum[c] = w_sum[c] + SW'(r_win[i][j][PW-1-CW*c -: CW]);
                    end
                end
            end
        end
    end

    // restoring divide, one quotient bit per cycle; quotient shifts into r_num
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_rsh[c]  = {r_rem[c], r_num[c][NW-1]};
            w_rsub[c] = w_rsh[c] - {1'b0, r_den};
            w_qbit[c] = w_rsh[c] >= {1'b0, r_den};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
        end else if (i_cmd.sum) begin
            r_step <= '0;
        end else if (i_cmd.div_step) begin
            r_step <= r_step + bbe_pkg::STEP_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sum) begin
            for (int c = 0; c < 3; c++) begin
                r_num[c] <= {w_sum[c], 1'b0} + NW'(w_cnt);
                r_rem[c] <= '0;
            end
            r_den <= {w_cnt, 1'b0};
            r_fe  <= w_fe;
        end else if (i_cmd.div_step) begin
            for (int c = 0; c < 3; c++) begin
                r_rem[c] <= w_qbit[c] ? w_rsub[c][DW-1:0] : w_rsh[c][DW-1:0];
                r_num[c] <= {r_num[c][NW-2:0], w_qbit[c]};
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            o_valid <= 1'b1;
        end else if (i_ready) begin
            o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_out_red   <= r_num[0][CW-1:0];
            o_out_green <= r_num[1][CW-1:0];
            o_out_blue  <= r_num[2][CW-1:0];
            o_frame_end <= r_fe;
        end
    end

    // controller status
    assign o_status.drop     = r_op && w_in_frame;
    assign o_status.emit     = (r_in_row >= RW'(2)) ||
                               ((r_in_row == RW'(1)) && (r_in_col != '0));
    assign o_status.div_done = r_step == bbe_pkg::STEP_W'(NW - 1);
    assign o_status.out_free = !o_valid || i_ready;

endmodule

// ===== rtl/core/box_blur_3x3_edge_average.sv =====
// ----------------------------------------------------------------------------
// box_blur_3x3_edge_average
// Streaming 3x3 box blur of RGB pixels with edge averaging.
// ----------------------------------------------------------------------------
// Pixels of one frame enter in raster order; each output is the per-channel
// mean of the in-image part of its 3x3 neighborhood (divisor 9, 6, 4, 3, 2 or
// 1), rounded half up. Output lags input by one row plus one pixel, so after
// the frame's last pixel send image_width+1 drain items (op=1) to flush; the
// last output carries frame_end. Width and height are latched at the first
// pixel of a frame. One item is in flight at a time: a dropped drain is
// accepted and checked, a pixel with no output also shifts the window, and
// an item that yields an output goes through accept, check, line-store read,
// window shift, sum, the 13-bit one-bit-per-cycle restoring divider, then the
// output register. A finished result waits in the output register while
// the next item is taken in. The config port is always ready; write it only
// between frames.
// ----------------------------------------------------------------------------
module box_blur_3x3_edge_average (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // config write channel
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [bbe_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bbe_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // input channel
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic                           i_op,
    input  logic [bbe_pkg::CH_W-1:0]       i_in_red,
    input  logic [bbe_pkg::CH_W-1:0]       i_in_green,
    input  logic [bbe_pkg::CH_W-1:0]       i_in_blue,
    // output channel
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [bbe_pkg::CH_W-1:0]       o_out_red,
    output logic [bbe_pkg::CH_W-1:0]       o_out_green,
    output logic [bbe_pkg::CH_W-1:0]       o_out_blue,
    output logic                           o_frame_end
);

    bbe_pkg::t_cmd    s_cmd;
    bbe_pkg::t_status s_status;

    // register writes complete in one transfer
    assign o_cfg_ready = 1'b1;

    bbe_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_status (s_status),
        .o_ready  (o_ready),
        .o_cmd    (s_cmd)
    );

    bbe_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (s_cmd),
        .o_status    (s_status),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_op        (i_op),
        .i_in_red    (i_in_red),
        .i_in_green  (i_in_green),
        .i_in_blue   (i_in_blue),
        .i_ready     (i_ready),
        .o_valid     (o_valid),
        .o_out_red   (o_out_red),
        .o_out_green (o_out_green),
        .o_out_blue  (o_out_blue),
        .o_frame_end (o_frame_end)
    );

`ifndef SYNTHESIS
    // an accepted item blocks further transfers until it is finished
    a_busy_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_cmd.load |=> !o_ready)
        else $error("input ready while an item is in work");

    // a loaded result is presented next cycle
    a_out_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_cmd.out_load |=> o_valid)
        else $error("result loaded but not presented");

    // sequencer issues one command at a time
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({s_cmd.load, s_cmd.rd, s_cmd.shift, s_cmd.sum,
                  s_cmd.div_step, s_cmd.out_load}))
        else $error("overlapping datapath commands");
`endif

endmodule

// ===== verif/box_blur_3x3_edge_average_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_blur_3x3_edge_average_tb
// Self-checking bench for the streaming 3x3 edge-averaging box blur.
// ----------------------------------------------------------------------------
// Frames of assorted sizes are streamed in raster order, each followed by
// flush items, with ignored drains mixed in. A scoreboard mirrors the line
// stores and window, predicts every output pixel and compares each transfer
// on the output channel. Both channels stall in random bursts, except in the
// closing stretch of the run.
// ----------------------------------------------------------------------------
module box_blur_3x3_edge_average_tb;

    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } t_blur_pix;

    // Mirror of the blur datapath plus the queue of pixels still owed.
    class blur_scoreboard;
        logic [23:0]  row_above[bbe_pkg::MAX_WIDTH];
        logic [23:0]  row_two_above[bbe_pkg::MAX_WIDTH];
        logic [23:0]  win[3][3];      // [column, 0 oldest][row, 0 top]
        int unsigned  row, col, left;
        int unsigned  reg_w, reg_h, fw, fh;
        t_blur_pix    owed[$];
        int           errors, items, results, frames;

        function void clear();
            foreach (row_above[k]) begin
                row_above[k]     = '0;
                row_two_above[k] = '0;
            end
            foreach (win[a, b]) win[a][b] = '0;
            row = 0; col = 0; left = 0;
            reg_w = bbe_pkg::MAX_WIDTH; reg_h = 1; fw = 1; fh = 1;
            errors = 0; items = 0; results = 0; frames = 0;
        endfunction

        function void write_reg(logic [7:0] idx, logic [15:0] data);
            if (idx == bbe_pkg::REG_IMAGE_WIDTH) reg_w = data & 16'h7FF;
            else if (idx == bbe_pkg::REG_IMAGE_HEIGHT) reg_h = data;
        endfunction

        function bit in_frame();
            return row != 0 || col != 0;
        endfunction

        function void note_input(logic op, logic [7:0] r, logic [7:0] g, logic [7:0] b);
            logic [23:0] pix, ta, ab, p;
            int unsigned orow, ocol, sr, sg, sb, cnt, c;
            bit          emit;
            t_blur_pix   res;
            pix = {r, g, b};
            sr = 0; sg = 0; sb = 0; cnt = 0;
            if (row == 0 && col == 0) begin
                if (op) return;   // drain with no frame open
                fw = reg_w < 1 ? 1 :
                     (reg_w > bbe_pkg::MAX_WIDTH ? bbe_pkg::MAX_WIDTH : reg_w);
                fh = reg_h == 0 ? 1 : reg_h;
                left = fw * fh;
            end
            if (row < fh) begin
                if (op) return;   // drain while pixels are still due
            end else begin
                pix = '0;         // past the last row: acts as a flush
            end
            items++;
            c = col % bbe_pkg::MAX_WIDTH;
            ta = row_two_above[c];
            ab = row_above[c];
            row_two_above[c] = ab;
            row_above[c]     = pix;
            for (int i = 0; i < 2; i++)
                for (int j = 0; j < 3; j++) win[i][j] = win[i+1][j];
            win[2][0] = ta; win[2][1] = ab; win[2][2] = pix;
            emit = row >= 2 || (row == 1 && col >= 1);
            if (col >= 1) begin
                orow = row - 1; ocol = col - 1;
            end else begin
                orow = row - 2; ocol = fw - 1;
            end
            col++;
            if (col >= fw) begin
                col = 0; row++;
            end
            if (!emit) return;
            for (int i = 0; i < 3; i++) begin
                if (i == 0 && ocol < 1) continue;
                if (i == 2 && ocol + 1 >= fw) continue;
                for (int j = 0; j < 3; j++) begin
                    if (j == 0 && orow < 1) continue;
                    if (j == 2 && orow + 1 >= fh) continue;
                    p = win[i][j];
                    sr += p[23:16]; sg += p[15:8]; sb += p[7:0];
                    cnt++;
                end
            end
            if (left > 0) left--;
            res.last = left == 0;
            if (res.last) begin
                row = 0; col = 0; frames++;
            end
            // round half up
            res.red   = 8'((2*sr + cnt) / (2*cnt));
            res.green = 8'((2*sg + cnt) / (2*cnt));
            res.blue  = 8'((2*sb + cnt) / (2*cnt));
            owed.push_back(res);
        endfunction

        function void check_result(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic fe);
            t_blur_pix want;
            results++;
            if (owed.size() == 0) begin
                $display("%0t: unexpected output pixel %h %h %h fe=%b", $time, r, g, b, fe);
                errors++;
                return;
            end
            want = owed.pop_front();
            if (r !== want.red) begin
                $display("%0t: red expected %h actual %h", $time, want.red, r);
                errors++;
            end
            if (g !== want.green) begin
                $display("%0t: green expected %h actual %h", $time, want.green, g);
                errors++;
            end
            if (b !== want.blue) begin
                $display("%0t: blue expected %h actual %h", $time, want.blue, b);
                errors++;
            end
            if (fe !== want.last) begin
                $display("%0t: frame_end expected %b actual %b", $time, want.last, fe);
                errors++;
            end
        endfunction
    endclass

    logic       i_clk, i_rst_n;
    logic       i_cfg_valid, o_cfg_ready;
    logic [bbe_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [bbe_pkg::CFG_DATA_W-1:0] i_cfg_data;
    logic       i_valid, o_ready, i_op;
    logic [7:0] i_in_red, i_in_green, i_in_blue;
    logic       o_valid, i_ready;
    logic [7:0] o_out_red, o_out_green, o_out_blue;
    logic       o_frame_end;

    blur_scoreboard sb = new();
    bit             calm;       // closing stretch: no stalls on either side
    bit             in_high;    // i_valid currently driven high

    box_blur_3x3_edge_average dut (.*);

    always begin
        i_clk = 1'b0; #5;
        i_clk = 1'b1; #5;
    end

    initial begin
        #20ms;
        $display("box_blur_3x3_edge_average_tb: done, errors");
        $finish;
    end

    // Output side: check every transfer, stall in random bursts.
    initial begin
        int stall;
        stall = 0;
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready)
                sb.check_result(o_out_red, o_out_green, o_out_blue, o_frame_end);
            if (stall > 0) begin
                stall--;
                i_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                stall = $urandom_range(1, 10) - 1;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // One input transfer, then an optional idle burst.
    task automatic send_item(logic op, logic [7:0] r, logic [7:0] g, logic [7:0] b);
        int gap;
        i_valid <= 1'b1; in_high = 1;
        i_op <= op; i_in_red <= r; i_in_green <= g; i_in_blue <= b;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sb.note_input(op, r, g, b);
        gap = (!calm && $urandom_range(0, 5) == 0) ? $urandom_range(1, 10) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0; in_high = 0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    function automatic logic [7:0] chan();
        case ($urandom_range(0, 5))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Let every owed pixel come out, then give trailing items time to retire.
    task automatic wait_quiet();
        int guard;
        guard = 0;
        if (in_high) begin
            i_valid <= 1'b0; in_high = 0;
        end
        while (sb.owed.size() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (30) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [7:0] idx, logic [15:0] data);
        i_cfg_valid <= 1'b1; i_cfg_index <= idx; i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.write_reg(idx, data);
        i_cfg_valid <= 1'b0;
    endtask

    // A whole frame: pixels with stray drains, then flush until frame_end.
    task automatic run_frame(logic [15:0] w, logic [15:0] h, int noise);
        wait_quiet();
        cfg_write(bbe_pkg::REG_IMAGE_WIDTH, w);
        cfg_write(bbe_pkg::REG_IMAGE_HEIGHT, h);
        if (noise > 0) send_item(1'b1, chan(), chan(), chan());   // idle drain, ignored
        send_item(1'b0, chan(), chan(), chan());
        while (sb.in_frame() && sb.row < sb.fh) begin
            if (noise > 0 && $urandom_range(0, noise) == 0)
                send_item(1'b1, chan(), chan(), chan());          // mid-frame drain, ignored
            else
                send_item(1'b0, chan(), chan(), chan());
        end
        // flush; a pixel item here acts as a drain
        while (sb.in_frame())
            send_item($urandom_range(0, 3) != 0, chan(), chan(), chan());
    endtask

    initial begin
        int w, h;
        sb.clear();
        calm = 0; in_high = 0;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0; i_op <= 1'b0;
        i_in_red <= '0; i_in_green <= '0; i_in_blue <= '0;
        i_cfg_valid <= 1'b0; i_cfg_index <= '0; i_cfg_data <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: degenerate sizes, unknown index, extremes of the registers.
        cfg_write(8'd2, 16'hFFFF);                        // no such register
        cfg_write(bbe_pkg::REG_IMAGE_HEIGHT, 16'hFFFF);   // overwritten before any frame
        run_frame(16'd0, 16'd0, 1);                       // both act as 1
        run_frame(16'd3, 16'd3, 3);
        run_frame(16'd2, 16'd1, 0);
        run_frame(16'd1, 16'd4, 2);

        // Random frames, mostly small; some single rows, some with stray width bits.
        while (sb.items < 1450) begin
            if (sb.items > 1150) calm = 1;
            case ($urandom_range(0, 19))
                0: begin w = $urandom_range(13, 64); h = 0; end      // height acts as 1
                1: begin w = 16'h0800 | $urandom_range(1, 12); h = $urandom_range(1, 8); end
                default: begin w = $urandom_range(1, 12); h = $urandom_range(1, 8); end
            endcase
            run_frame(16'(w), 16'(h), $urandom_range(0, 3) == 0 ? 0 : 15);
        end
        wait_quiet();

        $display("Streamed %0d frames, %0d blur items, checked %0d output pixels.",
                 sb.frames, sb.items, sb.results);
        if (sb.errors == 0 && sb.owed.size() == 0) begin
            $display("box_blur_3x3_edge_average_tb: done, clean");
        end else begin
            $display("%0d mismatches, %0d pixels never arrived", sb.errors, sb.owed.size());
            $display("box_blur_3x3_edge_average_tb: done, errors");
        end
        $finish;
    end
endmodule
